// ===== design/ipac_pkg.sv =====
package ipac_pkg;

  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;
  localparam logic [7:0] CH_DOT     = 8'd46;
  localparam logic [7:0] CH_COLON   = 8'd58;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_F = 8'd70;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_F = 8'd102;

  localparam int unsigned GROUP_W   = 9;
  localparam logic [GROUP_W-1:0] GROUP_MAX = 9'd255;
  localparam logic [GROUP_W-1:0] GROUP_SAT = 9'd256;

  localparam logic [2:0] DOTS_SAT   = 3'd7;
  localparam logic [2:0] DOTS_V4    = 3'd3;
  localparam logic [2:0] HEX_MAX    = 3'd4;
  localparam logic [3:0] COLONS_SAT = 4'd15;
  localparam logic [3:0] COLONS_MIN = 4'd2;
  localparam logic [3:0] COLONS_ALL = 4'd7;

  typedef enum logic [1:0] {
    KIND_INVALID = 2'd0,
    KIND_IPV4    = 2'd1,
    KIND_IPV6    = 2'd2
  } kind_t;

  typedef struct packed {
    logic fatal;   // dotted side hit an error while still in dotted form
    logic left;    // dotted side bailed out on a colon or hex letter
    logic ok;      // four well-formed groups so far
  } v4_status_t;

  typedef struct packed {
    logic err;     // hex side failed or a dot was seen
    logic ok;      // colon count and double colon rule satisfied
  } v6_status_t;

  function automatic logic is_dec(input logic [7:0] c);
    is_dec = (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_hex_letter(input logic [7:0] c);
    is_hex_letter = ((c >= CH_UPPER_A) && (c <= CH_UPPER_F)) ||
                    ((c >= CH_LOWER_A) && (c <= CH_LOWER_F));
  endfunction

endpackage

// ===== design/ip_address_classifier.sv =====
// ip_address_classifier
// Input channel (in_valid/in_ready): one ASCII character per transaction on
// in_ch, with in_last high on the final character of an address string.
// Result channel (out_valid/out_ready): one transaction per string, carrying
// out_address_kind = 0 invalid, 1 IPv4, 2 IPv6. Characters with in_last low
// produce no result.
// A final character passes from the character register through the two
// recognizers' combinational update into the result register. Throughput: one
// character per cycle unless a final character waits behind a stalled result.
// Reset (rst_n low, synchronous) empties both registers and clears the
// recognizer state; that state is cleared again after every final character.
// When the receiver stalls, the result holds in the output register; non-final
// characters keep flowing, and a second final character waits in the
// character register, dropping in_ready until the result is taken.
module ip_address_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_address_kind
);
  import ipac_pkg::*;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_ch_r;
  logic       s1_last_r;
  logic       s1_go;
  logic       out_valid_r, out_valid_nxt;
  kind_t      out_kind_r, kind_nxt;
  v4_status_t v4_st;
  v6_status_t v6_st;

  assign s1_go    = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  ipac_v4 u_v4 (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_go),
    .clr     (s1_last_r),
    .ch      (s1_ch_r),
    .status  (v4_st)
  );

  ipac_v6 u_v6 (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_go),
    .clr     (s1_last_r),
    .ch      (s1_ch_r),
    .status  (v6_st)
  );

  always_comb begin
    if (v4_st.fatal) begin
      kind_nxt = KIND_INVALID;
    end else if (!v4_st.left) begin
      kind_nxt = v4_st.ok ? KIND_IPV4 : KIND_INVALID;
    end else begin
      kind_nxt = (!v6_st.err && v6_st.ok) ? KIND_IPV6 : KIND_INVALID;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_go && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_ch_r   <= in_ch;
      s1_last_r <= in_last;
    end
    if (s1_go && s1_last_r) begin
      out_kind_r <= kind_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_address_kind = out_kind_r;

`ifndef NO_ASSERTIONS
  a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_last_r) |=> out_valid_r)
    else $error("final character did not produce a result");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_ready))
    else $error("input stalled without a blocked final character");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_kind_r == KIND_INVALID || out_kind_r == KIND_IPV4 ||
                     out_kind_r == KIND_IPV6))
    else $error("result register holds an unused kind code");
`endif

endmodule

// ===== design/ipac_v4.sv =====
module ipac_v4 (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  logic                   clr,
  input  logic [7:0]             ch,
  output ipac_pkg::v4_status_t   status
);
  import ipac_pkg::*;

  logic [GROUP_W-1:0] group_value_r, group_value_nxt;
  logic [2:0]         dot_count_r, dot_count_nxt;
  logic               group_has_digit_r, group_has_digit_nxt;
  logic               left_r, left_nxt;
  logic               fatal_r, fatal_nxt;
  logic [11:0]        gv_ext;
  logic [11:0]        gv_mac;

  assign gv_ext = 12'(group_value_r);
  assign gv_mac = (gv_ext << 3) + (gv_ext << 1) + 12'(ch - CH_ZERO);

  always_comb begin
    group_value_nxt     = group_value_r;
    dot_count_nxt       = dot_count_r;
    group_has_digit_nxt = group_has_digit_r;
    left_nxt            = left_r;
    fatal_nxt           = fatal_r;
    if (!left_r && !fatal_r) begin
      if (is_dec(ch)) begin
        group_value_nxt     = (gv_mac > 12'(GROUP_SAT)) ? GROUP_SAT : gv_mac[GROUP_W-1:0];
        group_has_digit_nxt = 1'b1;
      end else if (ch == CH_DOT) begin
        if (!group_has_digit_r || group_value_r > GROUP_MAX) begin
          fatal_nxt = 1'b1;
        end else begin
          group_value_nxt     = '0;
          group_has_digit_nxt = 1'b0;
          if (dot_count_r < DOTS_SAT) begin
            dot_count_nxt = dot_count_r + 3'd1;
          end
        end
      end else if (ch == CH_COLON || is_hex_letter(ch)) begin
        left_nxt = 1'b1;
      end else begin
        fatal_nxt = 1'b1;
      end
    end
  end

  assign status.fatal = fatal_nxt;
  assign status.left  = left_nxt;
  assign status.ok    = (dot_count_nxt == DOTS_V4) && group_has_digit_nxt &&
                        (group_value_nxt <= GROUP_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && clr)) begin
      group_value_r     <= '0;
      dot_count_r       <= '0;
      group_has_digit_r <= 1'b0;
      left_r            <= 1'b0;
      fatal_r           <= 1'b0;
    end else if (step_en) begin
      group_value_r     <= group_value_nxt;
      dot_count_r       <= dot_count_nxt;
      group_has_digit_r <= group_has_digit_nxt;
      left_r            <= left_nxt;
      fatal_r           <= fatal_nxt;
    end
  end

endmodule

// ===== design/ipac_v6.sv =====
module ipac_v6 (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  logic                   clr,
  input  logic [7:0]             ch,
  output ipac_pkg::v6_status_t   status
);
  import ipac_pkg::*;

  logic [2:0] hex_digit_count_r, hex_digit_count_nxt;
  logic [3:0] colon_count_r, colon_count_nxt;
  logic       prev_was_colon_r, prev_was_colon_nxt;
  logic       double_colon_seen_r, double_colon_seen_nxt;
  logic       hex_error_r, hex_error_nxt;
  logic       dot_seen_r, dot_seen_nxt;

  always_comb begin
    hex_digit_count_nxt   = hex_digit_count_r;
    colon_count_nxt       = colon_count_r;
    prev_was_colon_nxt    = prev_was_colon_r;
    double_colon_seen_nxt = double_colon_seen_r;
    hex_error_nxt         = hex_error_r;
    dot_seen_nxt          = dot_seen_r;
    if (!hex_error_r && !dot_seen_r) begin
      if (ch == CH_COLON) begin
        if (prev_was_colon_r && double_colon_seen_r) begin
          hex_error_nxt = 1'b1;  // second double colon, count left alone
        end else begin
          if (prev_was_colon_r) begin
            double_colon_seen_nxt = 1'b1;
          end else begin
            hex_digit_count_nxt = '0;
            prev_was_colon_nxt  = 1'b1;
          end
          if (colon_count_r < COLONS_SAT) begin
            colon_count_nxt = colon_count_r + 4'd1;
          end
        end
      end else if (is_dec(ch) || is_hex_letter(ch)) begin
        prev_was_colon_nxt  = 1'b0;
        hex_digit_count_nxt = hex_digit_count_r + 3'd1;
        if (hex_digit_count_r >= HEX_MAX) begin
          hex_error_nxt = 1'b1;
        end
      end else if (ch == CH_DOT) begin
        dot_seen_nxt = 1'b1;
      end else begin
        hex_error_nxt = 1'b1;
      end
    end
  end

  assign status.err = hex_error_nxt || dot_seen_nxt;
  assign status.ok  = ((colon_count_nxt >= COLONS_MIN) && (colon_count_nxt < COLONS_ALL) &&
                       double_colon_seen_nxt) ||
                      ((colon_count_nxt == COLONS_ALL) && !double_colon_seen_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && clr)) begin
      hex_digit_count_r   <= '0;
      colon_count_r       <= '0;
      prev_was_colon_r    <= 1'b0;
      double_colon_seen_r <= 1'b0;
      hex_error_r         <= 1'b0;
      dot_seen_r          <= 1'b0;
    end else if (step_en) begin
      hex_digit_count_r   <= hex_digit_count_nxt;
      colon_count_r       <= colon_count_nxt;
      prev_was_colon_r    <= prev_was_colon_nxt;
      double_colon_seen_r <= double_colon_seen_nxt;
      hex_error_r         <= hex_error_nxt;
      dot_seen_r          <= dot_seen_nxt;
    end
  end

endmodule
